FILE: sv/mfrf_pkg.sv
// Package for the MAC frame receive filter: configuration indexes, verdict codes,
// stage-to-stage structs and the byte-wide reflected CRC-16 step.
// No dependencies.
package mfrf_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPTED_TYPE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME_LENGTH = 2'd2;

  localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;
  localparam logic [15:0] BROADCAST_ADDRESS  = 16'hFFFF;
  localparam logic [7:0]  MIN_LENGTH_RESET   = 8'd13;
  localparam logic [7:0]  BYTE_COUNT_MAX     = 8'hFF;

  // Byte offsets of the captured header fields.
  localparam logic [7:0] OFS_TYPE     = 8'd1;
  localparam logic [7:0] OFS_DEST_LO  = 8'd5;
  localparam logic [7:0] OFS_DEST_HI  = 8'd6;
  localparam logic [7:0] OFS_SRC_LO   = 8'd9;
  localparam logic [7:0] OFS_SRC_HI   = 8'd10;
  localparam logic [7:0] OFS_LENGTH   = 8'd11;

  typedef enum logic [2:0] {
    VERDICT_TOO_SHORT  = 3'd0,
    VERDICT_CRC_ERROR  = 3'd1,
    VERDICT_NOT_FOR_ME = 3'd2,
    VERDICT_OWN_FRAME  = 3'd3,
    VERDICT_WRONG_TYPE = 3'd4,
    VERDICT_ACCEPTED   = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [15:0] own_address;
    logic [7:0]  accepted_type;
    logic [7:0]  min_frame_length;
  } config_t;

  // Everything the verdict stage needs about one finished frame.
  typedef struct packed {
    logic [7:0]  byte_count;
    logic [15:0] crc_residue;
    logic [15:0] dest_field;
    logic [15:0] source_field;
    logic [7:0]  type_field;
    logic [7:0]  length_field;
  } summary_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = b[k] ^ crc[0];
      crc = {1'b0, crc[15:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY_REFLECTED;
      end
    end
    return crc;
  endfunction

endpackage

FILE: sv/mfrf_if.sv
// Handshake interfaces for the byte input channel and the verdict result channel.
// Depends on mfrf_pkg for the verdict type.
interface mfrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mfrf_out_if;
  logic              valid;
  logic              ready;
  mfrf_pkg::verdict_t verdict;
  logic [15:0]       sender_address;
  logic [7:0]        payload_length;
  logic [31:0]       frames_counted;
  logic [31:0]       crc_failures;

  modport source (output valid, output verdict, output sender_address, output payload_length,
                  output frames_counted, output crc_failures, input ready);
  modport sink (input valid, input verdict, input sender_address, input payload_length,
                input frames_counted, input crc_failures, output ready);
endinterface

FILE: sv/mac_frame_receive_filter_core.sv
// Receive-side MAC frame filter. Frame bytes enter one per beat on in_s, the last
// byte flagged by frame_end; a byte can be taken every cycle while in_s.ready is high,
// since the CRC-16 step is unrolled over all eight bits of a byte. in_s.ready drops
// only while the summary register holds a finished frame that the result register,
// itself still waiting on out_m, cannot take. For each frame one verdict beat leaves
// on out_m through the summary register, then the result register; bytes without
// frame_end give no result. Configuration writes on cfg_* take effect at once and
// are meant for when no frame is in flight.
// Depends on mfrf_pkg, mfrf_if, mfrf_parse and mfrf_judge.
module mac_frame_receive_filter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  mfrf_in_if.sink                            in_s,
  mfrf_out_if.source                         out_m,
  input  logic                               cfg_we,
  input  logic [mfrf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mfrf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mfrf_pkg::*;

  config_t  cfg_r, cfg_nxt;
  logic     sum_valid;
  summary_t sum_data;
  logic     judge_ready;
  logic     in_fire;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:      cfg_nxt.own_address      = cfg_wdata;
        CFG_ACCEPTED_TYPE:    cfg_nxt.accepted_type    = cfg_wdata[7:0];
        CFG_MIN_FRAME_LENGTH: cfg_nxt.min_frame_length = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address      <= '0;
      cfg_r.accepted_type    <= '0;
      cfg_r.min_frame_length <= MIN_LENGTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The summary register frees up whenever the verdict stage can take it.
  assign in_s.ready = !sum_valid || judge_ready;
  assign in_fire    = in_s.valid && in_s.ready;

  mfrf_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .rx_byte     (in_s.rx_byte),
    .frame_end   (in_s.frame_end),
    .judge_ready (judge_ready),
    .sum_valid   (sum_valid),
    .sum_data    (sum_data)
  );

  mfrf_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .sum_valid   (sum_valid),
    .sum_data    (sum_data),
    .judge_ready (judge_ready),
    .out_m       (out_m)
  );

endmodule

FILE: sv/mfrf_parse.sv
// Per-frame parser: runs the CRC, counts bytes and captures header fields, then
// registers a frame summary on the last beat. Depends on mfrf_pkg.
module mfrf_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         rx_byte,
  input  logic               frame_end,
  input  logic               judge_ready,
  output logic               sum_valid,
  output mfrf_pkg::summary_t sum_data
);
  import mfrf_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [15:0] dest_r, dest_nxt;
  logic [15:0] src_r, src_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        sum_valid_r, sum_valid_nxt;
  summary_t    sum_r, sum_nxt;
  summary_t    cur;

  always_comb begin
    cur.byte_count   = (index_r == BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : index_r + 8'd1;
    cur.crc_residue  = crc16_byte(crc_r, rx_byte);
    cur.dest_field   = dest_r;
    cur.source_field = src_r;
    cur.type_field   = type_r;
    cur.length_field = len_r;
    unique case (index_r)
      OFS_TYPE:    cur.type_field   = rx_byte;
      OFS_DEST_LO: cur.dest_field   = {dest_r[15:8], rx_byte};
      OFS_DEST_HI: cur.dest_field   = {rx_byte, dest_r[7:0]};
      OFS_SRC_LO:  cur.source_field = {src_r[15:8], rx_byte};
      OFS_SRC_HI:  cur.source_field = {rx_byte, src_r[7:0]};
      OFS_LENGTH:  cur.length_field = rx_byte;
      default: ;
    endcase
  end

  always_comb begin
    crc_nxt       = crc_r;
    index_nxt     = index_r;
    dest_nxt      = dest_r;
    src_nxt       = src_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    sum_valid_nxt = judge_ready ? 1'b0 : sum_valid_r;
    if (in_fire) begin
      if (frame_end) begin
        // The frame is finished: hand its summary on and start the next one clean.
        sum_nxt       = cur;
        sum_valid_nxt = 1'b1;
        crc_nxt       = '0;
        index_nxt     = '0;
        dest_nxt      = '0;
        src_nxt       = '0;
        type_nxt      = '0;
        len_nxt       = '0;
      end else begin
        crc_nxt   = cur.crc_residue;
        index_nxt = cur.byte_count;
        dest_nxt  = cur.dest_field;
        src_nxt   = cur.source_field;
        type_nxt  = cur.type_field;
        len_nxt   = cur.length_field;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      index_r     <= '0;
      dest_r      <= '0;
      src_r       <= '0;
      type_r      <= '0;
      len_r       <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      index_r     <= index_nxt;
      dest_r      <= dest_nxt;
      src_r       <= src_nxt;
      type_r      <= type_nxt;
      len_r       <= len_nxt;
      sum_valid_r <= sum_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum_valid = sum_valid_r;
  assign sum_data  = sum_r;

endmodule

FILE: sv/mfrf_judge.sv
// Verdict stage: classifies a finished frame, keeps the frame and CRC error
// counters and holds the result register. Depends on mfrf_pkg.
module mfrf_judge (
  input  logic               clk,
  input  logic               rst_n,
  input  mfrf_pkg::config_t  cfg,
  input  logic               sum_valid,
  input  mfrf_pkg::summary_t sum_data,
  output logic               judge_ready,
  mfrf_out_if.source         out_m
);
  import mfrf_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [31:0] errors_r, errors_nxt;
  verdict_t    verdict_r, verdict_nxt;
  logic [15:0] sender_r, sender_nxt;
  logic [7:0]  length_r, length_nxt;
  logic        take;

  assign judge_ready = !out_valid_r || out_m.ready;
  assign take        = sum_valid && judge_ready;

  always_comb begin
    out_valid_nxt = out_m.ready ? 1'b0 : out_valid_r;
    frames_nxt    = frames_r;
    errors_nxt    = errors_r;
    verdict_nxt   = verdict_r;
    sender_nxt    = sender_r;
    length_nxt    = length_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      sender_nxt    = sum_data.source_field;
      length_nxt    = sum_data.length_field;
      if (sum_data.byte_count < cfg.min_frame_length) begin
        verdict_nxt = VERDICT_TOO_SHORT;
      end else begin
        frames_nxt = frames_r + 32'd1;
        if (sum_data.crc_residue != '0) begin
          errors_nxt  = errors_r + 32'd1;
          verdict_nxt = VERDICT_CRC_ERROR;
        end else if (sum_data.dest_field != BROADCAST_ADDRESS &&
                     sum_data.dest_field != cfg.own_address) begin
          verdict_nxt = VERDICT_NOT_FOR_ME;
        end else if (sum_data.source_field == cfg.own_address) begin
          verdict_nxt = VERDICT_OWN_FRAME;
        end else if (sum_data.type_field != cfg.accepted_type) begin
          verdict_nxt = VERDICT_WRONG_TYPE;
        end else begin
          verdict_nxt = VERDICT_ACCEPTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frames_r    <= '0;
      errors_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      frames_r    <= frames_nxt;
      errors_r    <= errors_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    sender_r  <= sender_nxt;
    length_r  <= length_nxt;
  end

  assign out_m.valid          = out_valid_r;
  assign out_m.verdict        = verdict_r;
  assign out_m.sender_address = sender_r;
  assign out_m.payload_length = length_r;
  assign out_m.frames_counted = frames_r;
  assign out_m.crc_failures   = errors_r;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for mac_frame_receive_filter_core: frames go in byte by byte,
// and every verdict beat is compared with a behavioral model kept in this file.
// Depends on mfrf_pkg, mfrf_if and the core RTL.
module tb_top;
  import mfrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct {
    verdict_t    verdict;
    logic [15:0] sender_address;
    logic [7:0]  payload_length;
    logic [31:0] frames_counted;
    logic [31:0] crc_failures;
  } verdict_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mfrf_in_if in_ch ();
  mfrf_out_if out_ch ();

  mac_frame_receive_filter_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_ch),
    .out_m    (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Model copy of the registers and of the per-frame and running state.
  logic [15:0] own_addr;
  logic [7:0]  acc_type;
  logic [7:0]  min_len;
  logic [15:0] rx_crc;
  logic [7:0]  rx_count;
  logic [15:0] rx_dest;
  logic [15:0] rx_src;
  logic [7:0]  rx_type;
  logic [7:0]  rx_plen;
  logic [31:0] frames_seen;
  logic [31:0] crc_errors;

  verdict_beat_t verdict_q[$];
  logic [7:0] frame_buf[$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned sent_bytes;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycle_count, verdict_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [15:0] fcs_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ data[i]) ? ((r >> 1) ^ CRC_POLY_REFLECTED) : (r >> 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH cycle %0d %s: got %0h, expected %0h", cycle_count, what, got, want);
  endtask

  // Advance the model by one accepted byte; the last byte of a frame queues a verdict.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    verdict_beat_t beat;
    case (rx_count)
      OFS_TYPE:    rx_type = b;
      OFS_DEST_LO: rx_dest[7:0] = b;
      OFS_DEST_HI: rx_dest[15:8] = b;
      OFS_SRC_LO:  rx_src[7:0] = b;
      OFS_SRC_HI:  rx_src[15:8] = b;
      OFS_LENGTH:  rx_plen = b;
      default: ;
    endcase
    rx_crc = fcs_step(rx_crc, b);
    if (rx_count != BYTE_COUNT_MAX) rx_count++;
    if (last) begin
      if (rx_count < min_len) begin
        beat.verdict = VERDICT_TOO_SHORT;
      end else begin
        frames_seen++;
        if (rx_crc != 16'h0000) begin
          crc_errors++;
          beat.verdict = VERDICT_CRC_ERROR;
        end else if (rx_dest != BROADCAST_ADDRESS && rx_dest != own_addr) begin
          beat.verdict = VERDICT_NOT_FOR_ME;
        end else if (rx_src == own_addr) begin
          beat.verdict = VERDICT_OWN_FRAME;
        end else if (rx_type != acc_type) begin
          beat.verdict = VERDICT_WRONG_TYPE;
        end else begin
          beat.verdict = VERDICT_ACCEPTED;
        end
      end
      beat.sender_address = rx_src;
      beat.payload_length = rx_plen;
      beat.frames_counted = frames_seen;
      beat.crc_failures = crc_errors;
      verdict_q.push_back(beat);
      rx_crc = '0;
      rx_count = '0;
      rx_dest = '0;
      rx_src = '0;
      rx_type = '0;
      rx_plen = '0;
    end
  endtask

  always @(posedge clk) begin
    verdict_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict beat with none pending", 32'(out_ch.verdict), 32'd0);
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.verdict !== want.verdict)
          report_mismatch("verdict", 32'(out_ch.verdict), 32'(want.verdict));
        if (out_ch.sender_address !== want.sender_address)
          report_mismatch("sender_address", 32'(out_ch.sender_address),
                          32'(want.sender_address));
        if (out_ch.payload_length !== want.payload_length)
          report_mismatch("payload_length", 32'(out_ch.payload_length),
                          32'(want.payload_length));
        if (out_ch.frames_counted !== want.frames_counted)
          report_mismatch("frames_counted", out_ch.frames_counted, want.frames_counted);
        if (out_ch.crc_failures !== want.crc_failures)
          report_mismatch("crc_failures", out_ch.crc_failures, want.crc_failures);
      end
    end
  end

  // Each cycle the sender idles with probability send_idle_pct percent.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.frame_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Fill frame_buf with a frame of len bytes whose last two bytes are the FCS;
  // a bad FCS is made by flipping one bit anywhere in the frame.
  task automatic build_frame(input int len, input logic [7:0] ftype, input logic [15:0] dest,
                             input logic [15:0] src, input logic [7:0] plen,
                             input bit good_fcs);
    logic [15:0] fcs;
    int flip;
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    if (len > 1) frame_buf[1] = ftype;
    if (len > 5) frame_buf[5] = dest[7:0];
    if (len > 6) frame_buf[6] = dest[15:8];
    if (len > 9) frame_buf[9] = src[7:0];
    if (len > 10) frame_buf[10] = src[15:8];
    if (len > 11) frame_buf[11] = plen;
    if (len >= 2) begin
      fcs = '0;
      for (int i = 0; i < len - 2; i++) fcs = fcs_step(fcs, frame_buf[i]);
      frame_buf[len-2] = fcs[7:0];
      frame_buf[len-1] = fcs[15:8];
    end
    if (!good_fcs) begin
      flip = $urandom_range(len * 8 - 1);
      frame_buf[flip/8] = frame_buf[flip/8] ^ (8'd1 << (flip % 8));
    end
  endtask

  task automatic send_crafted(input int len, input logic [7:0] ftype, input logic [15:0] dest,
                              input logic [15:0] src, input bit good_fcs);
    build_frame(len, ftype, dest, src, 8'($urandom), good_fcs);
    send_frame();
  endtask

  // The sender holds off until every pending verdict has been checked.
  task automatic wait_for_verdicts();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_OWN_ADDRESS:      own_addr = data;
      CFG_ACCEPTED_TYPE:    acc_type = data[7:0];
      CFG_MIN_FRAME_LENGTH: min_len = data[7:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] addr, input logic [7:0] ftype,
                           input logic [7:0] min_bytes);
    wait_for_verdicts();
    write_reg(CFG_OWN_ADDRESS, addr);
    write_reg(CFG_ACCEPTED_TYPE, {8'h00, ftype});
    write_reg(CFG_MIN_FRAME_LENGTH, {8'h00, min_bytes});
  endtask

  task automatic random_config();
    logic [15:0] addr;
    logic [7:0] ftype;
    logic [7:0] min_bytes;
    case ($urandom_range(2))
      0: addr = 16'h0000;
      1: addr = 16'hFFFF;
      default: addr = 16'($urandom);
    endcase
    case ($urandom_range(2))
      0: ftype = 8'h00;
      1: ftype = 8'hFF;
      default: ftype = 8'($urandom);
    endcase
    case ($urandom_range(9))
      0: min_bytes = 8'd0;
      1: min_bytes = 8'd255;
      2: min_bytes = 8'($urandom);
      default: min_bytes = 8'($urandom_range(11, 15));
    endcase
    configure(addr, ftype, min_bytes);
  endtask

  // Mostly well-formed frames, half of them aimed at this node or broadcast, then short frames and pure noise.
  task automatic random_frame();
    int kind;
    int len;
    logic [15:0] dest;
    logic [15:0] src;
    logic [7:0] ftype;
    kind = $urandom_range(99);
    if (kind < 65)
      len = ($urandom_range(29) == 0) ? $urandom_range(40, 270) : $urandom_range(13, 30);
    else if (kind < 80)
      len = $urandom_range(1, 14);
    else
      len = $urandom_range(1, 25);
    case ($urandom_range(3))
      0: dest = own_addr;
      1: dest = BROADCAST_ADDRESS;
      default: dest = 16'($urandom);
    endcase
    src = ($urandom_range(4) == 0) ? own_addr : 16'($urandom);
    ftype = $urandom_range(1) ? acc_type : 8'($urandom);
    if (kind < 65) begin
      build_frame(len, ftype, dest, src, 8'($urandom), $urandom_range(9) != 0);
    end else if (kind < 80) begin
      build_frame(len, ftype, dest, src, 8'($urandom), $urandom_range(1) == 1);
    end else begin
      frame_buf.delete();
      for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    end
    send_frame();
  endtask

  // Reset values: own address 0, accepted type 0, minimum length 13.
  task automatic test_reset_defaults();
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_frame();
    send_crafted(12, 8'h00, 16'h0000, 16'h0001, 1'b1);
    send_crafted(13, 8'h00, 16'h0000, 16'h8001, 1'b1);
    send_crafted(13, 8'h00, 16'h0000, 16'h0000, 1'b1);
  endtask

  task automatic test_each_verdict();
    configure(16'h1234, 8'hA5, 8'd13);
    send_crafted(16, 8'hA5, 16'h4321, 16'h0042, 1'b0);
    send_crafted(16, 8'hA5, 16'h4321, 16'h0042, 1'b1);
    send_crafted(16, 8'hA5, 16'h1234, 16'h1234, 1'b1);
    send_crafted(16, 8'h5A, 16'h1234, 16'h0042, 1'b1);
    send_crafted(16, 8'hA5, 16'h1234, 16'h0042, 1'b1);
    send_crafted(13, 8'hA5, BROADCAST_ADDRESS, 16'hFFFE, 1'b1);
  endtask

  // Zero and maximum minimum length, all-ones registers and a byte count past 255.
  task automatic test_length_extremes();
    configure(16'h1234, 8'hA5, 8'd0);
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    frame_buf.delete();
    frame_buf.push_back(8'h5A);
    send_frame();
    send_crafted(4, 8'hA5, 16'h1234, 16'h0042, 1'b1);
    configure(16'hFFFF, 8'hFF, 8'd255);
    send_crafted(255, 8'hFF, 16'hFFFF, 16'h0000, 1'b1);
    send_crafted(257, 8'hFF, 16'hFFFF, 16'h0000, 1'b1);
    send_crafted(257, 8'hFF, 16'hFFFF, 16'h0000, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned nbytes);
    int unsigned stop_at;
    stop_at = sent_bytes + nbytes;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_config();
    while (sent_bytes < stop_at) begin
      if ($urandom_range(11) == 0) begin
        if ($urandom_range(1) == 1) random_config();
        else wait_for_verdicts();
      end
      random_frame();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    sent_bytes = 0;
    send_idle_pct = 9;
    recv_idle_pct = 69;
    own_addr = 16'h0000;
    acc_type = 8'h00;
    min_len = MIN_LENGTH_RESET;
    rx_crc = '0;
    rx_count = '0;
    rx_dest = '0;
    rx_src = '0;
    rx_type = '0;
    rx_plen = '0;
    frames_seen = '0;
    crc_errors = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_each_verdict();
    test_length_extremes();
    test_random_traffic(9, 69, 140);
    test_random_traffic(69, 9, 140);
    test_random_traffic(0, 0, 140);

    wait_for_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
